FILE: src/dpp_pkg.sv
// shared types, constants and tables of the depth to point projector
package dpp_pkg;

    localparam int GRID_SIZE_DEF = 128;

    localparam int DEPTH_W    = 16;
    localparam int IDX_W      = 7;
    localparam int NEAR_W     = 24;
    localparam int FOV_W      = 16;
    localparam int TRIG_W     = 16;
    localparam int SHIFT_W    = 32;
    localparam int DIST_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int COLOR_W    = 8;

    localparam int CORDIC_STEPS = 24;
    localparam int ANG_W        = 33;
    localparam int CAM_W        = 42;
    localparam int CAM_QW       = 41;

    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [CAM_W-1:0] t_cam;

    localparam t_ang CORDIC_ONE  = 33'sd1073741824;
    localparam t_ang HALF_PI_Q30 = 33'sd1686629713;

    localparam t_ang ATAN_Q30 [0:CORDIC_STEPS-1] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128
    };

    localparam logic [CAM_QW-1:0] CAM_LIMIT = 41'h100_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_NEAR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SPAN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOV_ANGLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_COS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_SIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z    = 3'd7;

    typedef struct packed {
        logic [NEAR_W-1:0]  depth_near;
        logic [NEAR_W-1:0]  depth_span;
        logic [FOV_W-1:0]   fov_angle;
        logic [TRIG_W-1:0]  tilt_cos;
        logic [TRIG_W-1:0]  tilt_sin;
        logic [SHIFT_W-1:0] shift_x;
        logic [SHIFT_W-1:0] shift_y;
        logic [SHIFT_W-1:0] shift_z;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        depth_near: 24'd0,
        depth_span: 24'd1048576,
        fov_angle:  16'd25736,
        tilt_cos:   16'd16384,
        tilt_sin:   16'd0,
        shift_x:    32'd0,
        shift_y:    32'd0,
        shift_z:    32'd0
    };

endpackage

FILE: src/dpp_div.sv
// two-lane pipelined restoring divider, one quotient bit per stage
module dpp_div #(
    parameter int NW = 43,
    parameter int DW = 8,
    parameter int QW = 31,
    parameter int SW = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [1:0][NW-1:0]    i_num,
    input  logic [1:0][DW-1:0]    i_den,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [1:0][QW-1:0]    o_quo,
    output logic [1:0]            o_ovf,
    output logic [SW-1:0]         o_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [QW:0]            r_vld;
    logic [1:0][DW-1:0]     r_rem  [0:QW];
    logic [1:0][DW-1:0]     r_den  [0:QW];
    logic [1:0][QW-1:0]     r_low  [0:QW];
    logic [1:0][QW-1:0]     r_quo  [0:QW];
    logic [1:0]             r_ovf  [0:QW];
    logic [SW-1:0]          r_side [0:QW];

    logic [1:0][DW-1:0]     n_rem0;
    logic [1:0]             n_ovf0;

    // leading numerator bits decide overflow and seed the remainder
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_ovf0[l] = CW'(i_num[l][NW-1:QW]) >= CW'(i_den[l]);
            n_rem0[l] = n_ovf0[l] ? '0 : DW'(i_num[l][NW-1:QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= n_ovf0;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
            for (int l = 0; l < 2; l++) begin
                r_low[0][l] <= i_num[l][QW-1:0];
            end
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [1:0][DW:0]   w_trial;
        logic [1:0]         w_ge;
        logic [1:0][DW-1:0] n_rem;
        logic [1:0][QW-1:0] n_quo;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_trial[l] = {r_rem[k-1][l], r_low[k-1][l][B]};
                w_ge[l]    = w_trial[l] >= {1'b0, r_den[k-1][l]};
                n_rem[l]   = w_ge[l] ? DW'(w_trial[l] - {1'b0, r_den[k-1][l]})
                                     : DW'(w_trial[l]);
                n_quo[l]    = r_quo[k-1][l];
                n_quo[l][B] = w_ge[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= r_den[k-1];
                r_low[k]  <= r_low[k-1];
                r_quo[k]  <= n_quo;
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_quo[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_side  = r_side[QW];

endmodule

FILE: src/dpp_cordic.sv
// two-lane pipelined rotation cordic giving scaled cosine and sine
module dpp_cordic #(
    parameter int SW = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  dpp_pkg::t_ang       i_theta [0:1],
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output dpp_pkg::t_ang       o_x [0:1],
    output dpp_pkg::t_ang       o_y [0:1],
    output logic [SW-1:0]       o_side
);
    import dpp_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic [N:0]    r_vld;
    t_ang          r_x    [0:N][0:1];
    t_ang          r_y    [0:N][0:1];
    t_ang          r_th   [0:N][0:1];
    logic [SW-1:0] r_side [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < 2; l++) begin
                r_x[0][l]  <= CORDIC_ONE;
                r_y[0][l]  <= '0;
                r_th[0][l] <= i_theta[l];
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                for (int l = 0; l < 2; l++) begin
                    if (r_th[k][l] >= 0) begin
                        r_x[k+1][l]  <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l]  <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_th[k+1][l] <= r_th[k][l] - ATAN_Q30[k];
                    end else begin
                        r_x[k+1][l]  <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l]  <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_th[k+1][l] <= r_th[k][l] + ATAN_Q30[k];
                    end
                end
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_side  = r_side[N];
    assign o_x     = r_x[N];
    assign o_y     = r_y[N];

endmodule

FILE: src/dpp_post.sv
// tilt, offset, saturation, crop test and pseudo-color stages
module dpp_post (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  dpp_pkg::t_cfg               i_cfg,
    input  dpp_pkg::t_cam               i_xcam,
    input  dpp_pkg::t_cam               i_ycam,
    input  logic [dpp_pkg::DIST_W-1:0]  i_dist,
    output logic                        o_valid,
    output logic                        o_inside,
    output logic signed [31:0]          o_px,
    output logic signed [31:0]          o_py,
    output logic signed [31:0]          o_pz,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_blue
);
    import dpp_pkg::*;

    localparam logic signed [17:0] K103     = 18'sd67502;
    localparam logic signed [17:0] K104     = 18'sd68157;
    localparam logic signed [31:0] BOX_XY   = 32'sd157286;
    localparam logic signed [31:0] BOX_NXY  = -32'sd157286;
    localparam logic signed [31:0] BOX_ZMIN = 32'sd100664;
    localparam logic signed [11:0] RED_MUL  = 12'sd800;
    localparam logic signed [11:0] BLUE_MUL = 12'sd1500;
    localparam logic signed [43:0] RED_OFF  = 44'sd125829120;
    localparam logic signed [44:0] BLUE_OFF = 45'sd150994944;
    localparam logic signed [47:0] SAT_MAX  = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN  = -48'sd2147483648;

    function automatic logic signed [31:0] f_sat(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'sh7fff_ffff;
        end else if (v < SAT_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [5:0] r_vld;

    logic signed [TRIG_W-1:0] w_cs, w_sn;
    logic signed [DIST_W:0]   w_ds;

    logic signed [59:0] r_p1_xk;
    logic signed [57:0] r_p1_ycs, r_p1_ysn;
    logic signed [41:0] r_p1_dsn, r_p1_dcs;

    logic signed [58:0] w_sy, w_sz;
    logic signed [43:0] r_p2_xc;
    logic signed [44:0] r_p2_yr, r_p2_zr;

    logic signed [62:0] r_p3_yk;
    logic signed [44:0] r_p3_xs;
    logic signed [45:0] r_p3_zs;
    logic               r_p3_xin;

    logic signed [47:0] w_yv;
    logic signed [31:0] w_px, w_py, w_pz;
    logic signed [31:0] r_p4_px, r_p4_py, r_p4_pz;
    logic               r_p4_in;

    logic signed [43:0] r_p5_rp;
    logic signed [44:0] r_p5_bp;
    logic signed [31:0] r_p5_px, r_p5_py, r_p5_pz;
    logic               r_p5_in;

    logic [21:0] w_b;
    logic [9:0]  w_s;
    logic [8:0]  w_t;
    logic [7:0]  w_m;

    logic signed [31:0] r_px, r_py, r_pz;
    logic               r_in;
    logic [7:0]         r_red, r_blue;

    assign w_cs = $signed(i_cfg.tilt_cos);
    assign w_sn = $signed(i_cfg.tilt_sin);
    assign w_ds = $signed({1'b0, i_dist});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // products of the camera point
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_xk  <= i_xcam * K103;
            r_p1_ycs <= i_ycam * w_cs;
            r_p1_ysn <= i_ycam * w_sn;
            r_p1_dsn <= w_ds * w_sn;
            r_p1_dcs <= w_ds * w_cs;
        end
    end

    assign w_sy = r_p1_ycs + r_p1_dsn;
    assign w_sz = r_p1_ysn - r_p1_dcs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_xc <= r_p1_xk[59:16];
            r_p2_yr <= w_sy[58:14];
            r_p2_zr <= w_sz[58:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3_yk  <= r_p2_yr * K104;
            r_p3_xs  <= r_p2_xc + $signed(i_cfg.shift_x);
            r_p3_zs  <= r_p2_zr + $signed(i_cfg.shift_z);
            r_p3_xin <= (r_p2_xc <= BOX_XY) && (r_p2_xc >= BOX_NXY);
        end
    end

    assign w_yv = $signed(r_p3_yk[62:16]) + $signed(i_cfg.shift_y);
    assign w_px = f_sat(r_p3_xs);
    assign w_py = f_sat(w_yv);
    assign w_pz = f_sat(r_p3_zs);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p4_px <= w_px;
            r_p4_py <= w_py;
            r_p4_pz <= w_pz;
            r_p4_in <= r_p3_xin && (w_py <= BOX_XY) && (w_py >= BOX_NXY)
                       && (w_pz >= BOX_ZMIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p5_rp <= r_p4_py * RED_MUL + RED_OFF;
            r_p5_bp <= r_p4_pz * BLUE_MUL - BLUE_OFF;
            r_p5_px <= r_p4_px;
            r_p5_py <= r_p4_py;
            r_p5_pz <= r_p4_pz;
            r_p5_in <= r_p4_in;
        end
    end

    // mod 255 by folding bytes
    assign w_b = r_p5_bp[41:20];
    assign w_s = 10'(w_b[7:0]) + 10'(w_b[15:8]) + 10'(w_b[21:16]);
    assign w_t = 9'(w_s[7:0]) + 9'(w_s[9:8]);
    assign w_m = (w_t >= 9'd255) ? 8'(w_t - 9'd255) : w_t[7:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= r_p5_px;
            r_py   <= r_p5_py;
            r_pz   <= r_p5_pz;
            r_in   <= r_p5_in;
            r_red  <= r_p5_in ? r_p5_rp[27:20] : 8'd0;
            r_blue <= r_p5_in ? 8'd255 - w_m : 8'd0;
        end
    end

    assign o_valid  = r_vld[5];
    assign o_inside = r_in;
    assign o_px     = r_px;
    assign o_py     = r_py;
    assign o_pz     = r_pz;
    assign o_red    = r_red;
    assign o_blue   = r_blue;

endmodule

FILE: src/depth_to_point_projector_core.sv
// depth to point projector top level
// pipeline from input transfer to output valid: input stage, 3-stage angle
// reciprocal divide, 25-stage cordic, 42-stage coordinate divider and 9 more stages
// throughput one pixel per clock; a stalled output freezes the whole pipeline
// reset (synchronous, active low) clears all valid bits and loads register defaults
module depth_to_point_projector_core #(
    parameter int GRID_SIZE = dpp_pkg::GRID_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // depth[15:0], pixel_row[22:16], pixel_col[29:23], zero[31:30]
    input  logic [31:0]                        i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], red[103:96],
    // green[111:104], blue[119:112]
    output logic [119:0]                       o_m_axis_tdata,
    // inside_box[0]
    output logic [0:0]                         o_m_axis_tuser,
    input  logic                               i_cfg_wr_en,
    input  logic [dpp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dpp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import dpp_pkg::*;

    localparam int G1      = GRID_SIZE - 1;
    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam int MW      = $clog2(2 * IDX_MAX + G1 + 1);
    localparam int TDW     = $clog2(2 * G1 + 1);
    localparam int PW      = FOV_W + MW;
    localparam int DC      = $clog2(2 * G1);
    localparam int RS1     = PW + TDW;
    localparam int M1W     = RS1 - DC + 2;
    localparam int AW      = PW + M1W - RS1;
    localparam int RS2     = 2 * TDW;
    localparam int M2W     = RS2 + 16 - DC + 2;
    localparam int CNW     = DIST_W + 31;
    localparam int CDW     = 31;
    localparam int SSW     = DIST_W + 2;

    localparam longint TH_DL = 2 * G1;

    localparam logic [MW:0]     G1_V   = (MW+1)'(G1);
    localparam logic [TDW-1:0]  TH_DEN = TDW'(2 * G1);
    localparam logic [M1W-1:0]  RCP1   = M1W'(((longint'(1) <<< RS1) + TH_DL - 1) / TH_DL);
    localparam logic [M2W-1:0]  RCP2   =
        M2W'(((longint'(1) <<< (RS2 + 16)) + TH_DL - 1) / TH_DL);
    localparam logic [7:0]      GREEN  = 8'd160;

    logic w_en;
    t_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_DEPTH_NEAR: r_cfg.depth_near <= i_cfg_wdata[NEAR_W-1:0];
                REG_DEPTH_SPAN: r_cfg.depth_span <= i_cfg_wdata[NEAR_W-1:0];
                REG_FOV_ANGLE:  r_cfg.fov_angle  <= i_cfg_wdata[FOV_W-1:0];
                REG_TILT_COS:   r_cfg.tilt_cos   <= i_cfg_wdata[TRIG_W-1:0];
                REG_TILT_SIN:   r_cfg.tilt_sin   <= i_cfg_wdata[TRIG_W-1:0];
                REG_SHIFT_X:    r_cfg.shift_x    <= i_cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Y:    r_cfg.shift_y    <= i_cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Z:    r_cfg.shift_z    <= i_cfg_wdata[SHIFT_W-1:0];
            endcase
        end
    end

    // input stage: depth product and angle numerators
    logic [DEPTH_W-1:0] w_depth;
    logic [IDX_W-1:0]   w_row, w_col;
    logic [MW:0]        w_ext_r, w_ext_c;
    logic [1:0]         w_neg;
    logic [MW-1:0]      w_m_r, w_m_c;

    assign w_depth = i_s_axis_tdata[15:0];
    assign w_row   = i_s_axis_tdata[22:16];
    assign w_col   = i_s_axis_tdata[29:23];
    assign w_ext_r = (MW+1)'({w_row, 1'b0});
    assign w_ext_c = (MW+1)'({w_col, 1'b0});
    assign w_neg[0] = w_ext_r < G1_V;
    assign w_neg[1] = w_ext_c < G1_V;
    assign w_m_r = w_neg[0] ? MW'(G1_V - w_ext_r) : MW'(w_ext_r - G1_V);
    assign w_m_c = w_neg[1] ? MW'(G1_V - w_ext_c) : MW'(w_ext_c - G1_V);

    logic                     r_s1_vld;
    logic [NEAR_W+DEPTH_W-1:0] r_s1_dprod;
    logic [FOV_W+MW-1:0]      r_s1_nr, r_s1_nc;
    logic [1:0]               r_s1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dprod <= r_cfg.depth_span * w_depth;
            r_s1_nr    <= r_cfg.fov_angle * w_m_r;
            r_s1_nc    <= r_cfg.fov_angle * w_m_c;
            r_s1_neg   <= w_neg;
        end
    end

    logic [DIST_W-1:0]    w_dist;

    assign w_dist = DIST_W'(r_cfg.depth_near) + DIST_W'(r_s1_dprod[39:16]);

    // angle magnitude by reciprocal multiplication: integer part, then fraction
    logic                    r_t1_vld;
    logic [1:0][PW+M1W-1:0]  r_t1_prod;
    logic [1:0][PW-1:0]      r_t1_p;
    logic [DIST_W-1:0]       r_t1_dist;
    logic [1:0]              r_t1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
        end else if (w_en) begin
            r_t1_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_prod[0] <= r_s1_nr * RCP1;
            r_t1_prod[1] <= r_s1_nc * RCP1;
            r_t1_p[0]    <= r_s1_nr;
            r_t1_p[1]    <= r_s1_nc;
            r_t1_dist    <= w_dist;
            r_t1_neg     <= r_s1_neg;
        end
    end

    logic [1:0][AW-1:0]  w_a;
    logic [1:0][TDW-1:0] w_r;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_a[l] = r_t1_prod[l][PW+M1W-1:RS1];
            w_r[l] = TDW'(r_t1_p[l] - (PW'(w_a[l]) * PW'(TH_DEN)));
        end
    end

    logic                 r_t2_vld;
    logic [1:0][AW-1:0]   r_t2_a;
    logic [1:0][TDW-1:0]  r_t2_r;
    logic [DIST_W-1:0]    r_t2_dist;
    logic [1:0]           r_t2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_vld <= 1'b0;
        end else if (w_en) begin
            r_t2_vld <= r_t1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t2_a    <= w_a;
            r_t2_r    <= w_r;
            r_t2_dist <= r_t1_dist;
            r_t2_neg  <= r_t1_neg;
        end
    end

    logic                    r_t3_vld;
    logic [1:0][TDW+M2W-1:0] r_t3_fp;
    logic [1:0][AW-1:0]      r_t3_a;
    logic [DIST_W-1:0]       r_t3_dist;
    logic [1:0]              r_t3_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_vld <= 1'b0;
        end else if (w_en) begin
            r_t3_vld <= r_t2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                r_t3_fp[l] <= r_t2_r[l] * RCP2;
            end
            r_t3_a    <= r_t2_a;
            r_t3_dist <= r_t2_dist;
            r_t3_neg  <= r_t2_neg;
        end
    end

    // clamp and sign the ray angles
    logic [1:0][AW+15:0] w_q;
    t_ang w_mag [0:1];
    t_ang r_th  [0:1];
    logic r_s3_vld;
    logic [DIST_W-1:0] r_s3_dist;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_q[l]   = {r_t3_a[l], r_t3_fp[l][RS2+15:RS2]};
            w_mag[l] = (w_q[l] > (AW+16)'(HALF_PI_Q30))
                       ? HALF_PI_Q30 : $signed({1'b0, w_q[l][31:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_t3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_dist <= r_t3_dist;
            for (int l = 0; l < 2; l++) begin
                r_th[l] <= r_t3_neg[l] ? -w_mag[l] : w_mag[l];
            end
        end
    end

    logic              w_co_vld;
    t_ang              w_co_x [0:1];
    t_ang              w_co_y [0:1];
    logic [DIST_W-1:0] w_co_dist;

    dpp_cordic #(
        .SW (DIST_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_vld),
        .i_theta (r_th),
        .i_side  (r_s3_dist),
        .o_valid (w_co_vld),
        .o_x     (w_co_x),
        .o_y     (w_co_y),
        .o_side  (w_co_dist)
    );

    // distance times |sine| over cosine
    t_ang                 w_ay [0:1];
    logic                 r_s4_vld;
    logic [1:0][CNW-1:0]  r_s4_num;
    logic [1:0][CDW-1:0]  r_s4_den;
    logic [1:0]           r_s4_sgn;
    logic [DIST_W-1:0]    r_s4_dist;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ay[l] = (w_co_y[l] < 0) ? -w_co_y[l] : w_co_y[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= w_co_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_dist <= w_co_dist;
            for (int l = 0; l < 2; l++) begin
                r_s4_num[l] <= w_co_dist * w_ay[l][CDW-1:0];
                r_s4_den[l] <= (w_co_x[l] < 33'sd1) ? CDW'(1) : w_co_x[l][CDW-1:0];
                r_s4_sgn[l] <= w_co_y[l] < 0;
            end
        end
    end

    logic                   w_cd_vld;
    logic [1:0][CAM_QW-1:0] w_cd_quo;
    logic [1:0]             w_cd_ovf;
    logic [SSW-1:0]         w_cd_side;

    dpp_div #(
        .NW (CNW),
        .DW (CDW),
        .QW (CAM_QW),
        .SW (SSW)
    ) u_coord_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_vld),
        .i_num   (r_s4_num),
        .i_den   (r_s4_den),
        .i_side  ({r_s4_dist, r_s4_sgn}),
        .o_valid (w_cd_vld),
        .o_quo   (w_cd_quo),
        .o_ovf   (w_cd_ovf),
        .o_side  (w_cd_side)
    );

    // saturate and sign the camera coordinates
    logic [1:0][CAM_QW-1:0] w_qs;
    t_cam                   r_cam [0:1];
    logic                   r_s5_vld;
    logic [DIST_W-1:0]      r_s5_dist;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_qs[l] = (w_cd_ovf[l] || (w_cd_quo[l] > CAM_LIMIT)) ? CAM_LIMIT : w_cd_quo[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s5_vld <= w_cd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_dist <= w_cd_side[SSW-1:2];
            for (int l = 0; l < 2; l++) begin
                r_cam[l] <= w_cd_side[l] ? -$signed({1'b0, w_qs[l]})
                                         : $signed({1'b0, w_qs[l]});
            end
        end
    end

    logic               w_pt_vld, w_pt_in;
    logic signed [31:0] w_pt_x, w_pt_y, w_pt_z;
    logic [7:0]         w_pt_red, w_pt_blue;

    dpp_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s5_vld),
        .i_cfg    (r_cfg),
        .i_xcam   (r_cam[1]),
        .i_ycam   (r_cam[0]),
        .i_dist   (r_s5_dist),
        .o_valid  (w_pt_vld),
        .o_inside (w_pt_in),
        .o_px     (w_pt_x),
        .o_py     (w_pt_y),
        .o_pz     (w_pt_z),
        .o_red    (w_pt_red),
        .o_blue   (w_pt_blue)
    );

    // pipeline advances unless a finished transfer is held at the output
    assign w_en            = !w_pt_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = w_pt_vld;
    assign o_m_axis_tdata  = {w_pt_blue, GREEN, w_pt_red, w_pt_z, w_pt_y, w_pt_x};
    assign o_m_axis_tuser  = w_pt_in;

endmodule
